@@ rtl/escaped_api_frame_encoder_top_assert.svh @@
// assertion macros for the escaped frame encoder
`ifndef ESCAPED_API_FRAME_ENCODER_TOP_ASSERT_SVH
`define ESCAPED_API_FRAME_ENCODER_TOP_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define AEF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aef assertion failed");

// antecedent holds, consequent holds in the next cycle
`define AEF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aef assertion failed");

`endif

@@ rtl/aef_pkg.sv @@
// shared constants, types and helpers of the escaped frame encoder
package aef_pkg;

    localparam logic [7:0] DELIM_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] XON_BYTE   = 8'h11;
    localparam logic [7:0] XOFF_BYTE  = 8'h13;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] CSUM_BASE  = 8'hFF;

    localparam int NUM_SEGS = 5;
    localparam int SEG_W    = 3;

    localparam logic [SEG_W-1:0] SEG_DELIM  = 3'd0;
    localparam logic [SEG_W-1:0] SEG_LEN_HI = 3'd1;
    localparam logic [SEG_W-1:0] SEG_LEN_LO = 3'd2;
    localparam logic [SEG_W-1:0] SEG_DATA   = 3'd3;
    localparam logic [SEG_W-1:0] SEG_CSUM   = 3'd4;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] len;
        logic [7:0]  sum;
    } item_t;

    typedef struct packed {
        logic [NUM_SEGS-1:0][7:0] seg_byte;
        logic [NUM_SEGS-1:0]      seg_esc;
        logic [SEG_W-1:0]         start_pos;
        logic                     has_csum;
    } run_t;

    function automatic logic needs_escape(input logic [7:0] b);
        return b inside {DELIM_BYTE, ESC_BYTE, XON_BYTE, XOFF_BYTE};
    endfunction

endpackage

@@ rtl/escaped_api_frame_encoder_top.sv @@
// top level of the escaped frame encoder: input register, running sum, emitter
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+----------------------------------------------------
//  input   | data_valid   | data_stall   | data_byte, first_of_frame, last_of_frame, frame_length
//  output  | stream_valid | stream_stall | out_byte, last_of_run, frame_done
//
// each transaction yields 1 to 9 output bytes (2 for an escaped byte),
// one per cycle from the emitter register while the output is not stalled
// the first output byte passes through the item register, the run register and the output register
// reset clears the running sum and all valid flags
// input stalls only while the item register is full and the emitter is still busy
`include "escaped_api_frame_encoder_top_assert.svh"

module escaped_api_frame_encoder_top
    import aef_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_of_frame,
    input  logic        last_of_frame,
    input  logic [15:0] frame_length,
    output logic        stream_valid,
    input  logic        stream_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        frame_done
);

    logic       item_valid_reg;
    item_t      item_reg;
    logic [7:0] sum_reg;

    logic       accept;
    logic       run_take;
    logic [7:0] sum_base;
    logic [7:0] sum_after;
    run_t       run;

    assign data_stall = item_valid_reg && !run_take;
    assign accept     = data_valid && !data_stall;

    // header restarts the sum
    assign sum_base  = first_of_frame ? 8'h00 : sum_reg;
    assign sum_after = sum_base + data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            sum_reg        <= 8'h00;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
                sum_reg        <= last_of_frame ? 8'h00 : sum_after;
            end
            else if (run_take)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data  <= data_byte;
            item_reg.first <= first_of_frame;
            item_reg.last  <= last_of_frame;
            item_reg.len   <= frame_length;
            item_reg.sum   <= sum_after;
        end
    end

    aef_segment u_segment (
        .item (item_reg),
        .run  (run)
    );

    aef_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .run_valid    (item_valid_reg),
        .run          (run),
        .run_take     (run_take),
        .stream_valid (stream_valid),
        .stream_stall (stream_stall),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .frame_done   (frame_done)
    );

    `AEF_ASSERT_NOW(a_done_ends_run, stream_valid && frame_done, last_of_run)
    `AEF_ASSERT_NOW(a_escape_not_final, stream_valid && out_byte == ESC_BYTE, !last_of_run)
    `AEF_ASSERT_NEXT(a_sum_cleared_after_last, accept && last_of_frame, sum_reg == 8'h00)
    `AEF_ASSERT_NOW(a_stall_needs_full, data_stall, item_valid_reg)

endmodule

@@ rtl/aef_segment.sv @@
// builds the segment list (header, payload, checksum) for one transaction
module aef_segment
    import aef_pkg::*;
(
    input  item_t item,
    output run_t  run
);

    logic [7:0] csum;

    assign csum = CSUM_BASE - item.sum;

    always_comb
    begin
        run.seg_byte[SEG_DELIM]  = DELIM_BYTE;
        run.seg_byte[SEG_LEN_HI] = item.len[15:8];
        run.seg_byte[SEG_LEN_LO] = item.len[7:0];
        run.seg_byte[SEG_DATA]   = item.data;
        run.seg_byte[SEG_CSUM]   = csum;

        // the delimiter itself is never stuffed
        run.seg_esc[SEG_DELIM]  = 1'b0;
        run.seg_esc[SEG_LEN_HI] = needs_escape(item.len[15:8]);
        run.seg_esc[SEG_LEN_LO] = needs_escape(item.len[7:0]);
        run.seg_esc[SEG_DATA]   = needs_escape(item.data);
        run.seg_esc[SEG_CSUM]   = needs_escape(csum);

        run.start_pos = item.first ? SEG_DELIM : SEG_DATA;
        run.has_csum  = item.last;
    end

endmodule

@@ rtl/aef_emitter.sv @@
// walks a segment list one output byte per cycle, while the output is not stalled, into the output register
module aef_emitter
    import aef_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       run_valid,
    input  run_t       run,
    output logic       run_take,
    output logic       stream_valid,
    input  logic       stream_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       frame_done
);

    logic             held_reg;
    run_t             run_reg;
    logic [SEG_W-1:0] pos_reg;
    logic             half_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic             out_done_reg;

    logic       cur_esc;
    logic [7:0] cur_raw;
    logic [7:0] cur_byte;
    logic       seg_end;
    logic       run_end;
    logic       out_load;
    logic       out_free;

    assign cur_esc  = run_reg.seg_esc[pos_reg];
    assign cur_raw  = run_reg.seg_byte[pos_reg];
    assign cur_byte = !cur_esc ? cur_raw : (half_reg ? (cur_raw ^ ESC_XOR) : ESC_BYTE);
    assign seg_end  = !cur_esc || half_reg;
    assign run_end  = seg_end
                      && (pos_reg == SEG_CSUM || (pos_reg == SEG_DATA && !run_reg.has_csum));

    assign out_free = !out_valid_reg || !stream_stall;
    assign out_load = held_reg && out_free;
    assign run_take = !held_reg || (out_load && run_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= SEG_DATA;
            half_reg      <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= held_reg;
            end
            if (run_take)
            begin
                held_reg <= run_valid;
                pos_reg  <= run.start_pos;
                half_reg <= 1'b0;
            end
            else if (out_load)
            begin
                if (seg_end)
                begin
                    pos_reg  <= pos_reg + 3'd1;
                    half_reg <= 1'b0;
                end
                else
                begin
                    half_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_take)
        begin
            run_reg <= run;
        end
        if (out_load)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= run_end;
            out_done_reg <= run_end && (pos_reg == SEG_CSUM);
        end
    end

    assign stream_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_run  = out_last_reg;
    assign frame_done   = out_done_reg;

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench of the escaped api frame encoder: stuffing, header, checksum, stalls
module tb_top;
    import aef_pkg::*;

    typedef struct {
        logic [7:0] value;
        logic       run_end;
        logic       frame_end;
    } stream_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        data_valid;
    logic        data_stall;
    logic [7:0]  data_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [15:0] frame_length;
    logic        stream_valid;
    logic        stream_stall;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        frame_done;

    stream_byte_t expected_stream[$];
    logic [7:0]   frame_sum;
    int           mismatch_count = 0;
    int           items_sent = 0;
    bit           tx_no_idle = 1'b0;
    bit           rx_no_idle = 1'b0;
    int           rx_hold_cycles = 0;

    escaped_api_frame_encoder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_valid     (data_valid),
        .data_stall     (data_stall),
        .data_byte      (data_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .frame_length   (frame_length),
        .stream_valid   (stream_valid),
        .stream_stall   (stream_stall),
        .out_byte       (out_byte),
        .last_of_run    (last_of_run),
        .frame_done     (frame_done)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("escaped_api_frame_encoder_top verification failed");
        $finish;
    end

    // queue one byte, stuffed if it collides with a control byte
    function automatic void push_stuffed(input logic [7:0] b);
        if (b == DELIM_BYTE || b == ESC_BYTE || b == XON_BYTE || b == XOFF_BYTE)
        begin
            expected_stream.push_back('{value: ESC_BYTE, run_end: 1'b0, frame_end: 1'b0});
            expected_stream.push_back('{value: b ^ ESC_XOR, run_end: 1'b0, frame_end: 1'b0});
        end
        else
        begin
            expected_stream.push_back('{value: b, run_end: 1'b0, frame_end: 1'b0});
        end
    endfunction

    function automatic void predict_frame_bytes(input logic [7:0] d, input logic f,
                                                input logic l, input logic [15:0] len);
        if (f)
        begin
            expected_stream.push_back('{value: DELIM_BYTE, run_end: 1'b0, frame_end: 1'b0});
            push_stuffed(len[15:8]);
            push_stuffed(len[7:0]);
            frame_sum = 8'h00;
        end
        frame_sum = frame_sum + d;
        push_stuffed(d);
        if (l)
        begin
            push_stuffed(CSUM_BASE - frame_sum);
            expected_stream[$].frame_end = 1'b1;
            frame_sum = 8'h00;
        end
        expected_stream[$].run_end = 1'b1;
    endfunction

    // entered just after a rising edge; returns at the edge that takes the transaction
    task automatic send_item(input logic [7:0] d, input logic f, input logic l,
                             input logic [15:0] len);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            data_valid <= 1'b0;
        end
        @(negedge clk);
        data_valid     <= 1'b1;
        data_byte      <= d;
        first_of_frame <= f;
        last_of_frame  <= l;
        frame_length   <= len;
        do
            @(posedge clk);
        while (data_stall);
        predict_frame_bytes(d, f, l, len);
        items_sent++;
    endtask

    // drops the input valid first so that nothing is taken twice while draining
    task automatic wait_stream_empty();
        int guard;
        guard = 0;
        @(negedge clk);
        data_valid <= 1'b0;
        while (expected_stream.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_data();
        logic [7:0] specials[4];
        specials = '{DELIM_BYTE, ESC_BYTE, XON_BYTE, XOFF_BYTE};
        if ($urandom_range(0, 3) == 0)
            return specials[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // output side: random stall before each byte, long hold when asked
    initial
    begin
        int n;
        stream_byte_t want;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
            begin
                n = rx_no_idle ? 0 : $urandom_range(0, 6);
            end
            repeat (n)
            begin
                @(negedge clk);
                stream_stall <= 1'b1;
            end
            @(negedge clk);
            stream_stall <= 1'b0;
            do
                @(posedge clk);
            while (!stream_valid);
            if (expected_stream.size() == 0)
            begin
                $error("unexpected output byte %h", out_byte);
                mismatch_count++;
            end
            else
            begin
                want = expected_stream.pop_front();
                if (out_byte !== want.value)
                begin
                    $error("out_byte expected %h actual %h", want.value, out_byte);
                    mismatch_count++;
                end
                if (last_of_run !== want.run_end)
                begin
                    $error("last_of_run expected %b actual %b", want.run_end, last_of_run);
                    mismatch_count++;
                end
                if (frame_done !== want.frame_end)
                begin
                    $error("frame_done expected %b actual %b", want.frame_end, frame_done);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_header_and_length();
        send_item(8'h00, 1'b1, 1'b1, 16'h0001);
        send_item(8'hFF, 1'b1, 1'b1, 16'hFFFF);
        send_item(8'h40, 1'b1, 1'b1, 16'h0000);
        send_item(8'h01, 1'b1, 1'b1, 16'h7E7D);
        send_item(8'h02, 1'b1, 1'b1, 16'h1113);
    endtask

    task automatic test_escaping();
        logic [7:0] bytes[6];
        bytes = '{DELIM_BYTE, ESC_BYTE, XON_BYTE, XOFF_BYTE, ESC_XOR, 8'h5E};
        foreach (bytes[i])
            send_item(bytes[i], i == 0, i == 5, 16'd6);
        // sums that turn the checksum into each control byte
        send_item(8'h81, 1'b1, 1'b1, 16'd1);
        send_item(8'h82, 1'b1, 1'b1, 16'd1);
        send_item(8'hEE, 1'b1, 1'b1, 16'd1);
        send_item(8'hEC, 1'b1, 1'b1, 16'd1);
    endtask

    task automatic test_sum_continuation();
        // no first mark: the sum starts from zero, as the last frame end cleared it
        send_item(8'h10, 1'b0, 1'b0, 16'hA5A5);
        send_item(8'h20, 1'b0, 1'b1, 16'h5A5A);
        // a second header in mid frame restarts the sum
        send_item(8'h30, 1'b1, 1'b0, 16'd3);
        send_item(8'h40, 1'b1, 1'b0, 16'd2);
        send_item(8'h50, 1'b0, 1'b1, 16'hC3C3);
    endtask

    task automatic test_backpressure();
        tx_no_idle = 1'b1;
        rx_hold_cycles = 300;
        for (int i = 0; i < 30; i++)
            send_item(pick_data(), i == 0, i == 29, 16'd30);
        tx_no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        for (int k = 0; k < 2; k++)
        begin
            wait_stream_empty();
            for (int i = 0; i < 4; i++)
                send_item(pick_data(), i == 0, i == 3, 16'd4);
        end
    endtask

    task automatic test_random_frames();
        int flen;
        logic [15:0] len;
        while (items_sent < 370)
        begin
            tx_no_idle = ($urandom_range(0, 5) == 0);
            rx_no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // stray transactions with random marks
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
            end
            else
            begin
                flen = $urandom_range(1, 8);
                len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                  : 16'(flen);
                for (int i = 0; i < flen; i++)
                    send_item(pick_data(), i == 0, i == flen - 1,
                              (i == 0) ? len : 16'($urandom_range(0, 65535)));
            end
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    initial
    begin
        data_valid     = 1'b0;
        data_byte      = 8'h00;
        first_of_frame = 1'b0;
        last_of_frame  = 1'b0;
        frame_length   = 16'h0000;
        stream_stall   = 1'b0;
        frame_sum      = 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_and_length();
        test_escaping();
        test_sum_continuation();
        test_backpressure();
        test_drain_pause();
        test_random_frames();

        wait_stream_empty();
        if (expected_stream.size() != 0)
        begin
            $error("%0d output bytes never arrived", expected_stream.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("escaped_api_frame_encoder_top verification clean");
        else
            $display("escaped_api_frame_encoder_top verification failed");
        $finish;
    end

endmodule
